>>> rtl/iirdf1_pkg.sv
// Shared constants and types for the direct-form-one biquad filter.
package iirdf1_pkg;

    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int COEFF_FRAC_BITS_DEF = 15;
    localparam int TAP_COUNT_WIDTH     = 2;
    localparam int CFG_INDEX_WIDTH     = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_FF_COEFF_0   = 3'd0,
        REG_FF_COEFF_1   = 3'd1,
        REG_FF_COEFF_2   = 3'd2,
        REG_FB_COEFF_1   = 3'd3,
        REG_FB_COEFF_2   = 3'd4,
        REG_FF_TAP_COUNT = 3'd5,
        REG_FB_TAP_COUNT = 3'd6
    } cfg_reg_t;

    // Which taps take part in the sum
    typedef struct packed {
        logic ff0;
        logic ff1;
        logic ff2;
        logic fb1;
        logic fb2;
    } tap_en_t;

endpackage

>>> rtl/iirdf1_tap_cell.sv
// One history cell: holds a delayed sample, hands it on and weights it by its coefficient.
module iirdf1_tap_cell
    import iirdf1_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COEFF_WIDTH  = COEFF_FRAC_BITS_DEF + 3
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        shift,
    input  logic                                        tap_on,
    input  logic signed [COEFF_WIDTH-1:0]               coeff,
    input  logic signed [SAMPLE_WIDTH-1:0]              data_in,
    output logic signed [SAMPLE_WIDTH-1:0]              data_out,
    output logic signed [SAMPLE_WIDTH+COEFF_WIDTH-1:0]  product
);

    localparam int PROD_WIDTH = SAMPLE_WIDTH + COEFF_WIDTH;

    logic signed [SAMPLE_WIDTH-1:0] data_reg;
    logic signed [PROD_WIDTH-1:0]   mult;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (shift)
        begin
            data_reg <= data_in;
        end
    end

    assign mult     = data_reg * coeff;
    assign product  = tap_on ? mult : '0;
    assign data_out = data_reg;

endmodule

>>> rtl/iirdf1_accum.sv
// Sum of weighted taps, round half up, saturate to the sample width.
module iirdf1_accum
    import iirdf1_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
)
(
    input  tap_en_t                                                 tap_en,
    input  logic signed [SAMPLE_WIDTH-1:0]                          x,
    input  logic signed [COEFF_FRAC_BITS+2:0]                       b0,
    input  logic signed [SAMPLE_WIDTH+COEFF_FRAC_BITS+2:0]          ff_prod_1,
    input  logic signed [SAMPLE_WIDTH+COEFF_FRAC_BITS+2:0]          ff_prod_2,
    input  logic signed [SAMPLE_WIDTH+COEFF_FRAC_BITS+2:0]          fb_prod_1,
    input  logic signed [SAMPLE_WIDTH+COEFF_FRAC_BITS+2:0]          fb_prod_2,
    output logic signed [SAMPLE_WIDTH-1:0]                          y,
    output logic                                                    clip
);

    localparam int COEFF_WIDTH = COEFF_FRAC_BITS + 3;
    localparam int PROD_WIDTH  = SAMPLE_WIDTH + COEFF_WIDTH;
    localparam int ACC_WIDTH   = PROD_WIDTH + 3;
    localparam int EXT         = ACC_WIDTH - PROD_WIDTH;

    localparam logic signed [ACC_WIDTH-1:0] HALF   = ACC_WIDTH'(1) <<< (COEFF_FRAC_BITS - 1);
    localparam logic signed [ACC_WIDTH-1:0] SAT_HI = (ACC_WIDTH'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam logic signed [ACC_WIDTH-1:0] SAT_LO = -SAT_HI - 1;

    logic signed [PROD_WIDTH-1:0] b0_mult;
    logic signed [PROD_WIDTH-1:0] b0_prod;
    logic signed [ACC_WIDTH-1:0]  acc;
    logic signed [ACC_WIDTH-1:0]  rounded;

    assign b0_mult = x * b0;
    assign b0_prod = tap_en.ff0 ? b0_mult : '0;

    assign acc = $signed({{EXT{b0_prod[PROD_WIDTH-1]}},   b0_prod})
               + $signed({{EXT{ff_prod_1[PROD_WIDTH-1]}}, ff_prod_1})
               + $signed({{EXT{ff_prod_2[PROD_WIDTH-1]}}, ff_prod_2})
               - $signed({{EXT{fb_prod_1[PROD_WIDTH-1]}}, fb_prod_1})
               - $signed({{EXT{fb_prod_2[PROD_WIDTH-1]}}, fb_prod_2});

    // floor after adding one half
    assign rounded = (acc + HALF) >>> COEFF_FRAC_BITS;

    always_comb
    begin
        if (rounded > SAT_HI)
        begin
            y    = SAT_HI[SAMPLE_WIDTH-1:0];
            clip = 1'b1;
        end
        else if (rounded < SAT_LO)
        begin
            y    = SAT_LO[SAMPLE_WIDTH-1:0];
            clip = 1'b1;
        end
        else
        begin
            y    = rounded[SAMPLE_WIDTH-1:0];
            clip = 1'b0;
        end
    end

endmodule

>>> rtl/iir_direct_form_one_filter.sv
// Direct-form-one biquad: input and output history cells around one accumulator.
// The output word of an accepted input is registered, valid in the next cycle.
// Throughput: one word per cycle while out_ready is high; the feedback loop from
// the output history cells through the accumulator and saturation is combinational.
// Reset: histories clear to zero, b0 = 1.0, other coefficients zero, one
// feed-forward tap and no feedback taps; the output register is empty.
module iir_direct_form_one_filter
    import iirdf1_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    sample_out,
    output logic                              clipped,
    input  logic                              cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [COEFF_FRAC_BITS+2:0]        cfg_data
);

    localparam int COEFF_WIDTH = COEFF_FRAC_BITS + 3;
    localparam int PROD_WIDTH  = SAMPLE_WIDTH + COEFF_WIDTH;
    localparam logic signed [COEFF_WIDTH-1:0] COEFF_ONE = COEFF_WIDTH'(1) <<< COEFF_FRAC_BITS;

    logic signed [COEFF_WIDTH-1:0]   b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic [TAP_COUNT_WIDTH-1:0]      ff_count_reg, fb_count_reg;
    logic                            out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0]  sample_out_reg;
    logic                            clipped_reg;

    tap_en_t                         tap_en;
    logic                            accept;
    logic signed [SAMPLE_WIDTH-1:0]  x_d1, y_d1, y_next;
    logic                            clip_next;
    logic signed [PROD_WIDTH-1:0]    ff_prod_1, ff_prod_2, fb_prod_1, fb_prod_2;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign tap_en.ff0 = (ff_count_reg > 2'd0);
    assign tap_en.ff1 = (ff_count_reg > 2'd1);
    assign tap_en.ff2 = (ff_count_reg > 2'd2);
    assign tap_en.fb1 = (fb_count_reg >= 2'd1);
    assign tap_en.fb2 = (fb_count_reg >= 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg       <= COEFF_ONE;
            b1_reg       <= '0;
            b2_reg       <= '0;
            a1_reg       <= '0;
            a2_reg       <= '0;
            ff_count_reg <= TAP_COUNT_WIDTH'(1);
            fb_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FF_COEFF_0:   b0_reg       <= cfg_data;
                REG_FF_COEFF_1:   b1_reg       <= cfg_data;
                REG_FF_COEFF_2:   b2_reg       <= cfg_data;
                REG_FB_COEFF_1:   a1_reg       <= cfg_data;
                REG_FB_COEFF_2:   a2_reg       <= cfg_data;
                REG_FF_TAP_COUNT: ff_count_reg <= cfg_data[TAP_COUNT_WIDTH-1:0];
                REG_FB_TAP_COUNT: fb_count_reg <= cfg_data[TAP_COUNT_WIDTH-1:0];
                default:          ; // drop writes beyond the register list
            endcase
        end
    end

    // input history: x[n-1], x[n-2]
    iirdf1_tap_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEFF_WIDTH(COEFF_WIDTH)) u_ff_cell_1
    (
        .clk(clk), .rst_n(rst_n), .shift(accept), .tap_on(tap_en.ff1),
        .coeff(b1_reg), .data_in(sample_in), .data_out(x_d1), .product(ff_prod_1)
    );

    iirdf1_tap_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEFF_WIDTH(COEFF_WIDTH)) u_ff_cell_2
    (
        .clk(clk), .rst_n(rst_n), .shift(accept), .tap_on(tap_en.ff2),
        .coeff(b2_reg), .data_in(x_d1), .data_out(), .product(ff_prod_2)
    );

    // output history: y[n-1], y[n-2], saturated values
    iirdf1_tap_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEFF_WIDTH(COEFF_WIDTH)) u_fb_cell_1
    (
        .clk(clk), .rst_n(rst_n), .shift(accept), .tap_on(tap_en.fb1),
        .coeff(a1_reg), .data_in(y_next), .data_out(y_d1), .product(fb_prod_1)
    );

    iirdf1_tap_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEFF_WIDTH(COEFF_WIDTH)) u_fb_cell_2
    (
        .clk(clk), .rst_n(rst_n), .shift(accept), .tap_on(tap_en.fb2),
        .coeff(a2_reg), .data_in(y_d1), .data_out(), .product(fb_prod_2)
    );

    iirdf1_accum #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_accum
    (
        .tap_en(tap_en), .x(sample_in), .b0(b0_reg),
        .ff_prod_1(ff_prod_1), .ff_prod_2(ff_prod_2),
        .fb_prod_1(fb_prod_1), .fb_prod_2(fb_prod_2),
        .y(y_next), .clip(clip_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the output word until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_out_reg <= y_next;
            clipped_reg    <= clip_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

    a_accept_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted word did not reach the output register");

    a_feedback_matches_output: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (y_d1 == sample_out))
        else $error("output history out of step with the output word");

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clipped) |->
            ((sample_out == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}})
             || (sample_out == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}})))
        else $error("clipped word not at a saturation rail");

endmodule
